// ===== design/slpwk_pkg.sv =====
// ----------------------------------------------------------------------------
// slpwk_pkg
// Shared constants and controller/datapath interface types for the sleep
// wake-up table.
// ----------------------------------------------------------------------------
package slpwk_pkg;

    localparam int SLOTS     = 16;
    localparam int ID_BITS   = 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int TASK_ID_W = 8;
    localparam int WAKE_W    = 63;

    // s_axis_tdata: task_id, wake_time, current_time, zero padded to bytes
    localparam int IN_FIELDS_W  = TASK_ID_W + 2 * WAKE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    // m_axis_tdata: woken_id, earliest_wake, zero padded to bytes
    localparam int OUT_FIELDS_W = TASK_ID_W + WAKE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 2;

    localparam logic              CMD_SLEEP = 1'b0;
    localparam logic              CMD_TICK  = 1'b1;
    localparam logic [WAKE_W-1:0] WAKE_NONE = {WAKE_W{1'b1}};

    // Commands from controller to datapath
    typedef struct packed {
        logic              load_in;     // capture accepted input word
        logic              do_sleep;    // append entry and emit sleep result
        logic              scan_start;  // clear scan accumulators
        logic              scan_step;   // examine one table entry
        logic              scan_last;   // final entry of the scan
        logic [SLOT_W-1:0] scan_idx;
        logic              emit;        // load one tick result into output
        logic              emit_none;   // tick woke nobody
        logic              emit_last;
        logic [SLOT_W-1:0] emit_idx;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] nwoken;
        logic             out_free;
    } t_dp_stat;

endpackage

// ===== design/slpwk_ctrl.sv =====
// ----------------------------------------------------------------------------
// slpwk_ctrl
// Sequencer: accepts a word, runs the sleep append or the tick scan, then
// steps the woken results out.
// ----------------------------------------------------------------------------
module slpwk_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  slpwk_pkg::t_dp_stat i_stat,
    output slpwk_pkg::t_dp_cmd  o_cmd
);
    import slpwk_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_k, n_k;
    logic              w_scan_last;
    logic              w_emit_last;

    assign w_scan_last = ({1'b0, r_idx} + CNT_W'(1)) == i_stat.count;
    assign w_emit_last = (i_stat.nwoken == '0) ||
                         (({1'b0, r_k} + CNT_W'(1)) == i_stat.nwoken);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_k        = r_k;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.scan_idx  = r_idx;
        o_cmd.scan_last = w_scan_last;
        o_cmd.emit_idx  = r_k;
        o_cmd.emit_last = w_emit_last;
        o_cmd.emit_none = (i_stat.nwoken == '0);
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.cmd == CMD_SLEEP) begin
                    if (i_stat.out_free) begin
                        o_cmd.do_sleep = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_idx            = '0;
                    n_k              = '0;
                    n_state          = (i_stat.count == '0) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (w_scan_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (w_emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + SLOT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
        end
    end

endmodule

// ===== design/slpwk_dp.sv =====
// ----------------------------------------------------------------------------
// slpwk_dp
// Datapath: input word register, sleep table with in-place compaction,
// woken-id buffer, earliest-wake tracking and the output register.
// ----------------------------------------------------------------------------
module slpwk_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [slpwk_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [slpwk_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic [slpwk_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    output logic                              o_m_tlast,
    input  slpwk_pkg::t_dp_cmd                i_cmd,
    output slpwk_pkg::t_dp_stat               o_stat
);
    import slpwk_pkg::*;

    // Captured input word
    logic               r_cmd;
    logic [ID_BITS-1:0] r_task_id;
    logic [WAKE_W-1:0]  r_wake;
    logic [WAKE_W-1:0]  r_now;

    // Table and scan state
    logic [WAKE_W-1:0]  r_ent_wake [SLOTS];
    logic [ID_BITS-1:0] r_ent_id   [SLOTS];
    logic [ID_BITS-1:0] r_woken    [SLOTS];
    logic [CNT_W-1:0]   r_count, n_count;
    logic [WAKE_W-1:0]  r_min, n_min;
    logic [CNT_W-1:0]   r_keep;
    logic [CNT_W-1:0]   r_nwoken;

    // Output register
    logic                   r_out_valid;
    logic [TASK_ID_W-1:0]   r_out_id;
    logic [WAKE_W-1:0]      r_out_wake;
    logic                   r_out_woken;
    logic                   r_out_full;
    logic                   r_out_last;

    logic               w_full;
    logic [WAKE_W-1:0]  w_rd_wake;
    logic [ID_BITS-1:0] w_rd_id;
    logic               w_wakes;
    logic [CNT_W-1:0]   w_keep_next;

    assign w_full      = (r_count == CNT_W'(SLOTS));
    assign w_rd_wake   = r_ent_wake[i_cmd.scan_idx];
    assign w_rd_id     = r_ent_id[i_cmd.scan_idx];
    assign w_wakes     = (w_rd_wake <= r_now);
    assign w_keep_next = w_wakes ? r_keep : r_keep + CNT_W'(1);

    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        if (i_cmd.do_sleep && !w_full) begin
            n_count = r_count + CNT_W'(1);
            if (r_wake < r_min) begin
                n_min = r_wake;
            end
        end else if (i_cmd.scan_start) begin
            n_min = WAKE_NONE;
        end else if (i_cmd.scan_step) begin
            if (!w_wakes && (w_rd_wake < r_min)) begin
                n_min = w_rd_wake;
            end
            if (i_cmd.scan_last) begin
                n_count = w_keep_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min       <= WAKE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_min   <= n_min;
            if (i_cmd.do_sleep || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and table storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd     <= i_s_tuser;
            r_task_id <= i_s_tdata[ID_BITS-1:0];
            r_wake    <= i_s_tdata[TASK_ID_W +: WAKE_W];
            r_now     <= i_s_tdata[TASK_ID_W + WAKE_W +: WAKE_W];
        end
        if (i_cmd.do_sleep && !w_full) begin
            r_ent_wake[r_count[SLOT_W-1:0]] <= r_wake;
            r_ent_id[r_count[SLOT_W-1:0]]   <= r_task_id;
        end
        if (i_cmd.scan_start) begin
            r_keep   <= '0;
            r_nwoken <= '0;
        end else if (i_cmd.scan_step) begin
            if (w_wakes) begin
                r_woken[r_nwoken[SLOT_W-1:0]] <= w_rd_id;
                r_nwoken <= r_nwoken + CNT_W'(1);
            end else begin
                // close up survivors in their original order
                r_ent_wake[r_keep[SLOT_W-1:0]] <= w_rd_wake;
                r_ent_id[r_keep[SLOT_W-1:0]]   <= w_rd_id;
            end
            r_keep <= w_keep_next;
        end
        if (i_cmd.do_sleep) begin
            r_out_id    <= '0;
            r_out_woken <= 1'b0;
            r_out_last  <= 1'b1;
            r_out_full  <= w_full;
            r_out_wake  <= n_min;
        end else if (i_cmd.emit) begin
            r_out_id    <= i_cmd.emit_none ? '0 : TASK_ID_W'(r_woken[i_cmd.emit_idx]);
            r_out_woken <= !i_cmd.emit_none;
            r_out_last  <= i_cmd.emit_last;
            r_out_full  <= 1'b0;
            r_out_wake  <= r_min;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_wake, r_out_id});
    assign o_m_tuser  = {r_out_full, r_out_woken};
    assign o_m_tlast  = r_out_last;

    assign o_stat.cmd      = r_cmd;
    assign o_stat.count    = r_count;
    assign o_stat.nwoken   = r_nwoken;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

endmodule

// ===== design/sleep_wakeup_table_unit.sv =====
// ----------------------------------------------------------------------------
// sleep_wakeup_table_unit
// Alarm-clock sleep queue: a table of sleeping tasks woken by timer ticks.
// ----------------------------------------------------------------------------
// Usage: each input word is either a sleep request (tuser = 0) that appends
// a task id and wake tick to the table, or a timer tick (tuser = 1) carrying
// the current time. A sleep gives one result word: the new earliest wake
// tick, and a table_full flag when the table already holds SLOTS tasks (the
// request is then dropped). A tick removes every task whose wake tick is at
// or below the current time and returns one word per woken id in the order
// the tasks went to sleep, tlast on the final one; a tick that wakes nobody
// gives one word with woken_valid low. Every result of a tick carries the
// earliest wake tick recomputed over the survivors (all ones when the table
// is empty). The scan reads and compacts the table one entry per cycle
// and then steps woken ids out one per cycle while the output register
// is free to take them. A new word is accepted while a finished result
// still sits in the output register.
// ----------------------------------------------------------------------------
module sleep_wakeup_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] task_id, [70:8] wake_time, [133:71] current_time, rest zero
    input  logic [slpwk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] command: 0 sleep, 1 tick
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] woken_id, [70:8] earliest_wake, rest zero
    output logic [slpwk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] woken_valid, [1] table_full
    output logic [slpwk_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                              m_axis_tlast
);
    import slpwk_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: IDLE accepts, EXEC runs the sleep or starts a scan,
    // SCAN walks the table, EMIT streams the woken ids.
    slpwk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Table storage, compaction, earliest-wake tracking, output register
    slpwk_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule
